@@ rtl/multichannel_first_order_lowpass_core_macros.svh @@
// Assertion helpers for the low-pass core checker.
// They expect clk_i and rst_ni in scope.
`ifndef MULTICHANNEL_FIRST_ORDER_LOWPASS_CORE_MACROS_SVH
`define MULTICHANNEL_FIRST_ORDER_LOWPASS_CORE_MACROS_SVH

// Check a property on every rising edge outside reset.
`define MCLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define MCLP_ASSERT_NEXT(lbl, pre, post, msg) \
  `MCLP_ASSERT(lbl, (pre) |=> (post), msg)

`endif

@@ rtl/mclp_pkg.sv @@
`default_nettype none
package mclp_pkg;

  localparam int Channels  = 8;
  localparam int ChanW     = 3;
  localparam int FracBits  = 16;
  localparam int SampleW   = 32;
  localparam int ScaleW    = 16;
  localparam int ScaleFrac = 16;
  localparam int FbW       = 24;
  localparam int CfgW      = 24;

  // Product of feedback and stored output, and the sum that it feeds.
  localparam int ProdFbW = FbW + SampleW;
  localparam int SumW    = ProdFbW - FracBits + 2;
  // The sum is split into a low half (unsigned) and a high half (signed) for the scale product.
  localparam int SumLoW  = SumW / 2;
  localparam int SumHiW  = SumW - SumLoW;
  // Shared multiplier operands; scale as a signed value and each sum half fit.
  localparam int MulAW   = FbW;
  localparam int MulBW   = SampleW;
  localparam int MulPW   = MulAW + MulBW;
  localparam int FullW   = SumW + ScaleW + 1;
  localparam int YW      = FullW - ScaleFrac;

  localparam logic signed [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};

  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(32768);
  localparam logic [FbW-1:0]    FbReset    = '0;

  // Register indexes
  localparam logic RegScale    = 1'b0;
  localparam logic RegFeedback = 1'b1;

  // Item function codes
  localparam logic FuncFilter = 1'b0;
  localparam logic FuncReset  = 1'b1;

  typedef enum logic [1:0] {
    MulFb,
    MulLo,
    MulHi
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     load_reset;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     sum_en;
    logic     lo_en;
    logic     finish;
  } mclp_cmd_t;

endpackage
`default_nettype wire

@@ rtl/mclp_ctrl.sv @@
`default_nettype none
module mclp_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      func_i,
  input  wire logic [mclp_pkg::ChanW-1:0] channel_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output mclp_pkg::mclp_cmd_t            cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StMulFb,
    StSum,
    StMulLo,
    StMulHi,
    StFinish
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   chan_ok;
  logic   out_free;

  assign chan_ok    = int'(channel_i) < mclp_pkg::Channels;
  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.mul_sel    = mclp_pkg::MulFb;
    case (state_q)
      StIdle: begin
        if (accept && chan_ok) begin
          if (func_i == mclp_pkg::FuncReset) begin
            cmd_o.load_reset = 1'b1;
          end else begin
            cmd_o.load_in = 1'b1;
            state_d       = StMulFb;
          end
        end
      end
      StMulFb: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mclp_pkg::MulFb;
        state_d       = StSum;
      end
      StSum: begin
        cmd_o.sum_en = 1'b1;
        state_d      = StMulLo;
      end
      StMulLo: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mclp_pkg::MulLo;
        state_d       = StMulHi;
      end
      StMulHi: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = mclp_pkg::MulHi;
        cmd_o.lo_en   = 1'b1;
        state_d       = StFinish;
      end
      StFinish: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

@@ rtl/mclp_datapath.sv @@
`default_nettype none
module mclp_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire mclp_pkg::mclp_cmd_t                cmd_i,
  input  wire logic                               cfg_we_i,
  input  wire logic                               cfg_index_i,
  input  wire logic [mclp_pkg::CfgW-1:0]          cfg_data_i,
  input  wire logic [mclp_pkg::ChanW-1:0]         channel_i,
  input  wire logic signed [mclp_pkg::SampleW-1:0] sample_i,
  output logic [mclp_pkg::ChanW-1:0]              out_channel_o,
  output logic signed [mclp_pkg::SampleW-1:0]     filtered_o
);

  logic [mclp_pkg::ScaleW-1:0]         scale_q;
  logic signed [mclp_pkg::FbW-1:0]     fb_q;

  logic signed [mclp_pkg::SampleW-1:0] last_in_q  [mclp_pkg::Channels];
  logic signed [mclp_pkg::SampleW-1:0] last_out_q [mclp_pkg::Channels];

  logic [mclp_pkg::ChanW-1:0]          ch_q;
  logic signed [mclp_pkg::SampleW-1:0] x_q;

  logic signed [mclp_pkg::MulAW-1:0]   mul_a;
  logic signed [mclp_pkg::MulBW-1:0]   mul_b;
  logic signed [mclp_pkg::MulPW-1:0]   prod_d, prod_q;
  logic signed [mclp_pkg::MulPW-1:0]   lo_prod_q;

  logic signed [mclp_pkg::ProdFbW-mclp_pkg::FracBits-1:0] fb_term;
  logic signed [mclp_pkg::SumW-1:0]    sum_d, sum_q;
  logic signed [mclp_pkg::FullW-1:0]   full;
  logic signed [mclp_pkg::YW-1:0]      y_wide;
  logic signed [mclp_pkg::SampleW-1:0] y_sat;

  logic [mclp_pkg::ChanW-1:0]          out_channel_q;
  logic signed [mclp_pkg::SampleW-1:0] filtered_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= mclp_pkg::ScaleReset;
      fb_q    <= mclp_pkg::FbReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mclp_pkg::RegScale:    scale_q <= cfg_data_i[mclp_pkg::ScaleW-1:0];
        mclp_pkg::RegFeedback: fb_q    <= signed'(cfg_data_i[mclp_pkg::FbW-1:0]);
        default: ;
      endcase
    end
  end

  // Multiplier operand select; sum is split into unsigned low and signed high parts
  always_comb begin
    case (cmd_i.mul_sel)
      mclp_pkg::MulFb: begin
        mul_a = fb_q;
        mul_b = last_out_q[ch_q];
      end
      mclp_pkg::MulLo: begin
        mul_a = {{(mclp_pkg::MulAW-mclp_pkg::ScaleW){1'b0}}, scale_q};
        mul_b = {{(mclp_pkg::MulBW-mclp_pkg::SumLoW){1'b0}}, sum_q[mclp_pkg::SumLoW-1:0]};
      end
      mclp_pkg::MulHi: begin
        mul_a = {{(mclp_pkg::MulAW-mclp_pkg::ScaleW){1'b0}}, scale_q};
        mul_b = mclp_pkg::MulBW'(signed'(sum_q[mclp_pkg::SumW-1:mclp_pkg::SumLoW]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d  = mul_a * mul_b;
  assign fb_term = signed'(prod_q[mclp_pkg::MulPW-1:mclp_pkg::FracBits]);
  assign sum_d   = mclp_pkg::SumW'(x_q) + mclp_pkg::SumW'(last_in_q[ch_q])
                 - mclp_pkg::SumW'(fb_term);

  // Recombine the two halves of scale * sum, floor by the shift, then clamp
  assign full   = (mclp_pkg::FullW'(prod_q) <<< mclp_pkg::SumLoW)
                + mclp_pkg::FullW'(lo_prod_q);
  assign y_wide = signed'(full[mclp_pkg::FullW-1:mclp_pkg::ScaleFrac]);

  always_comb begin
    if (y_wide > mclp_pkg::YW'(mclp_pkg::SampleMax)) begin
      y_sat = mclp_pkg::SampleMax;
    end else if (y_wide < mclp_pkg::YW'(mclp_pkg::SampleMin)) begin
      y_sat = mclp_pkg::SampleMin;
    end else begin
      y_sat = y_wide[mclp_pkg::SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ch_q <= channel_i;
      x_q  <= sample_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.lo_en) begin
      lo_prod_q <= prod_q;
    end
    if (cmd_i.sum_en) begin
      sum_q <= sum_d;
    end
    if (cmd_i.finish) begin
      out_channel_q <= ch_q;
      filtered_q    <= y_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mclp_pkg::Channels; i++) begin
        last_in_q[i]  <= '0;
        last_out_q[i] <= '0;
      end
    end else if (cmd_i.load_reset) begin
      last_in_q[channel_i]  <= sample_i;
      last_out_q[channel_i] <= sample_i;
    end else if (cmd_i.finish) begin
      last_in_q[ch_q]  <= x_q;
      last_out_q[ch_q] <= y_sat;
    end
  end

  assign out_channel_o = out_channel_q;
  assign filtered_o    = filtered_q;

endmodule
`default_nettype wire

@@ rtl/multichannel_first_order_lowpass_core.sv @@
// Channel | Handshake            | Payload
// input   | in_valid_i/in_stall_o | func_i, channel_i, sample_i
// output  | out_valid_o/out_stall_i | out_channel_o, filtered_o
// config  | cfg_we_i             | cfg_index_i, cfg_data_i
//
// A filter item steps through the states MulFb, Sum, MulLo, MulHi and Finish; Finish
// writes the output register, and no new item is taken before the core is idle. The
// shared 24x32 multiplier is used three times (feedback, then the low and high halves of
// the scale product) with a sum and a recombine step around it.
// A reset item returns nothing and leaves the input free for the next item.
// Reset clears the channel stores and loads the coefficient defaults at once.
// A stalled result lets the next item run, but its Finish step and the input wait.
`default_nettype none
module multichannel_first_order_lowpass_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic                               cfg_index_i,
  input  wire logic [mclp_pkg::CfgW-1:0]          cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               func_i,
  input  wire logic [mclp_pkg::ChanW-1:0]         channel_i,
  input  wire logic signed [mclp_pkg::SampleW-1:0] sample_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [mclp_pkg::ChanW-1:0]              out_channel_o,
  output logic signed [mclp_pkg::SampleW-1:0]     filtered_o
);

  mclp_pkg::mclp_cmd_t cmd;

  mclp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .channel_i   (channel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  mclp_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .channel_i     (channel_i),
    .sample_i      (sample_i),
    .out_channel_o (out_channel_o),
    .filtered_o    (filtered_o)
  );

endmodule
`default_nettype wire

@@ rtl/mclp_checker.sv @@
`default_nettype none
`include "multichannel_first_order_lowpass_core_macros.svh"
module mclp_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_stall_o,
  input wire logic                               func_i,
  input wire logic                               out_valid_o,
  input wire logic                               out_stall_i,
  input wire logic signed [mclp_pkg::SampleW-1:0] filtered_o
);

  `MCLP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(filtered_o), "stalled result changed")
  `MCLP_ASSERT_NEXT(a_filter_busy, in_valid_i && !in_stall_o && func_i == mclp_pkg::FuncFilter, in_stall_o, "filter transfer did not occupy the core")
  `MCLP_ASSERT_NEXT(a_reset_quick, in_valid_i && !in_stall_o && func_i == mclp_pkg::FuncReset, !in_stall_o, "reset item held the input")
  `MCLP_ASSERT(a_out_from_work, $rose(out_valid_o) |-> $past(in_stall_o), "result appeared without work")

endmodule

bind multichannel_first_order_lowpass_core mclp_checker u_mclp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .func_i      (func_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .filtered_o  (filtered_o)
);
`default_nettype wire
